// ===== hw/rtl/nrss_pkg.sv =====
// shared types, codes and helpers of the note repeat step sequencer
package nrss_pkg;

  localparam int unsigned NRSS_DEPTH = 16;
  localparam int unsigned PITCH_W    = 16;
  localparam int unsigned BEATS_W    = 8;
  localparam int unsigned LFSR_W     = 16;
  localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;

  typedef enum logic [2:0] {
    OP_BEAT  = 3'd0,
    OP_PUSH  = 3'd1,
    OP_POP   = 3'd2,
    OP_CLEAR = 3'd3,
    OP_START = 3'd4,
    OP_STOP  = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    EV_OFF     = 2'd0,
    EV_ON      = 2'd1,
    EV_ALL_OFF = 2'd2
  } event_e;

  typedef enum logic [1:0] {
    STYLE_FORWARD  = 2'd0,
    STYLE_BACKWARD = 2'd1,
    STYLE_RANDOM   = 2'd2
  } style_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_POP,
    S_BEAT,
    S_DIV,
    S_NRD,
    S_NEW,
    S_EMIT_OFF,
    S_EMIT_ON,
    S_EMIT_ALL
  } state_e;

  typedef struct packed {
    logic signed [PITCH_W-1:0] pitch;
    logic                      rest;
    logic [BEATS_W-1:0]        len;
  } step_t;

  // pitch plus offset, clamped to the signed 16 bit range
  function automatic logic signed [PITCH_W-1:0] sat_add(
    input logic signed [PITCH_W-1:0] a,
    input logic signed [PITCH_W-1:0] b
  );
    logic signed [PITCH_W:0] s;
    logic signed [PITCH_W-1:0] r;
    s = {a[PITCH_W-1], a} + {b[PITCH_W-1], b};
    if (s[PITCH_W] != s[PITCH_W-1]) begin
      r = s[PITCH_W] ? {1'b1, {(PITCH_W-1){1'b0}}} : {1'b0, {(PITCH_W-1){1'b1}}};
    end else begin
      r = s[PITCH_W-1:0];
    end
    return r;
  endfunction

  function automatic logic [LFSR_W-1:0] lfsr_next(input logic [LFSR_W-1:0] s);
    logic fb;
    fb = s[0] ^ s[2] ^ s[3] ^ s[5];
    return {fb, s[LFSR_W-1:1]};
  endfunction

endpackage

// ===== hw/rtl/note_repeat_step_sequencer_top.sv =====
// note repeat step sequencer: step memory, sequencer and shared remainder unit
//
//   channel   dir  handshake                  beat payload
//   in        in   in_valid_i / in_stall_o    op, step_pitch, step_is_rest, step_beats,
//                                             start_offset
//   out       out  out_valid_o / out_stall_i  event_kind, note_pitch, last
//   cfg       in   cfg_valid_i / cfg_ready_o  style
//
// push, clear, start and ignored ops finish in idle; pop of the playing step goes through
// S_POP to its note off unless it is a rest; a beat that moves on goes through S_BEAT, S_DIV,
// S_NRD and S_NEW, where the 16 step one bit per cycle remainder unit picks the next step.
// the input is stalled from the accept until the sequencer is back in idle.
// results leave through one output register; the sequencer waits while it is stalled.
// reset is asynchronous, active low, and clears all control state; no clearing pass.
module note_repeat_step_sequencer_top
  import nrss_pkg::*;
#(
  parameter int unsigned DEPTH = NRSS_DEPTH
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [2:0]                op_i,
  input  logic signed [PITCH_W-1:0] step_pitch_i,
  input  logic                      step_is_rest_i,
  input  logic [BEATS_W-1:0]        step_beats_i,
  input  logic signed [PITCH_W-1:0] start_offset_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [1:0]                event_kind_o,
  output logic signed [PITCH_W-1:0] note_pitch_o,
  output logic                      last_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [1:0]                cfg_style_i
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam int unsigned IdxW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned BitW = $clog2(LFSR_W);

  state_e state_q, state_d;

  step_t mem_q [DEPTH];
  step_t rd_q;
  logic [IdxW-1:0] rd_addr;

  logic [CntW-1:0]           count_q, count_d;
  logic [IdxW-1:0]           idx_q, idx_d;
  logic                      idx_vld_q, idx_vld_d;
  logic [BEATS_W-1:0]        beats_q, beats_d;
  logic                      playing_q, playing_d;
  logic signed [PITCH_W-1:0] offset_q, offset_d;
  logic [LFSR_W-1:0]         lfsr_q, lfsr_d;
  logic [1:0]                style_q;

  logic [LFSR_W-1:0]         dvd_q, dvd_d;
  logic [CntW-1:0]           rem_q, rem_d;
  logic [BitW-1:0]           bit_cnt_q, bit_cnt_d;

  logic                      off_pend_q, off_pend_d;
  logic                      on_pend_q, on_pend_d;
  logic signed [PITCH_W-1:0] off_pitch_q, off_pitch_d;
  logic signed [PITCH_W-1:0] on_pitch_q, on_pitch_d;

  logic                      out_valid_q, out_valid_d;
  logic [1:0]                out_kind_q;
  logic signed [PITCH_W-1:0] out_pitch_q;
  logic                      out_last_q;

  logic                      ld;
  event_e                    ld_kind;
  logic signed [PITCH_W-1:0] ld_pitch;
  logic                      ld_last;
  logic                      slot_free;
  logic                      push_we;

  logic [CntW-1:0]           top;
  logic                      cur_is_top;
  logic                      cur_in_range;
  logic [CntW:0]             rem_shift;
  logic [CntW:0]             rem_next;
  logic [LFSR_W-1:0]         size_ext;
  logic [LFSR_W-1:0]         idx_ext;
  logic [LFSR_W-1:0]         lfsr_adv;
  logic signed [PITCH_W-1:0] rd_sat;

  assign in_stall_o  = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign slot_free   = !out_valid_q || !out_stall_i;

  assign top          = count_q - CntW'(1);
  assign cur_is_top   = idx_vld_q && (CntW'(idx_q) == top);
  assign cur_in_range = idx_vld_q && (CntW'(idx_q) < count_q);
  assign size_ext     = LFSR_W'(count_q);
  assign idx_ext      = LFSR_W'(idx_q);
  assign lfsr_adv     = lfsr_next(lfsr_q);
  assign rd_sat       = sat_add(rd_q.pitch, offset_q);

  // restoring remainder, one dividend bit per cycle
  assign rem_shift = {rem_q, dvd_q[LFSR_W-1]};
  assign rem_next  = (rem_shift >= {1'b0, count_q}) ? rem_shift - {1'b0, count_q} : rem_shift;

  assign push_we = (state_q == S_IDLE) && in_valid_i && (op_e'(op_i) == OP_PUSH) &&
                   (count_q < CntW'(DEPTH));

  always_comb begin
    if ((state_q == S_IDLE) && (op_e'(op_i) == OP_POP)) begin
      rd_addr = top[IdxW-1:0];
    end else begin
      rd_addr = idx_q;
    end
  end

  // step memory
  always_ff @(posedge clk_i) begin
    if (push_we) begin
      mem_q[count_q[IdxW-1:0]] <= '{pitch: step_pitch_i, rest: step_is_rest_i,
                                    len: step_beats_i};
    end
    rd_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      idx_q       <= '0;
      idx_vld_q   <= 1'b0;
      beats_q     <= '0;
      playing_q   <= 1'b0;
      offset_q    <= '0;
      lfsr_q      <= LFSR_SEED;
      style_q     <= STYLE_FORWARD;
      bit_cnt_q   <= '0;
      off_pend_q  <= 1'b0;
      on_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      idx_vld_q   <= idx_vld_d;
      beats_q     <= beats_d;
      playing_q   <= playing_d;
      offset_q    <= offset_d;
      lfsr_q      <= lfsr_d;
      bit_cnt_q   <= bit_cnt_d;
      off_pend_q  <= off_pend_d;
      on_pend_q   <= on_pend_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        style_q <= cfg_style_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q       <= dvd_d;
    rem_q       <= rem_d;
    off_pitch_q <= off_pitch_d;
    on_pitch_q  <= on_pitch_d;
    if (ld) begin
      out_kind_q  <= ld_kind;
      out_pitch_q <= ld_pitch;
      out_last_q  <= ld_last;
    end
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    idx_d       = idx_q;
    idx_vld_d   = idx_vld_q;
    beats_d     = beats_q;
    playing_d   = playing_q;
    offset_d    = offset_q;
    lfsr_d      = lfsr_q;
    dvd_d       = dvd_q;
    rem_d       = rem_q;
    bit_cnt_d   = bit_cnt_q;
    off_pend_d  = off_pend_q;
    on_pend_d   = on_pend_q;
    off_pitch_d = off_pitch_q;
    on_pitch_d  = on_pitch_q;
    ld          = 1'b0;
    ld_kind     = EV_OFF;
    ld_pitch    = '0;
    ld_last     = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          case (op_e'(op_i))
            OP_BEAT: begin
              if (playing_q && (count_q != '0)) begin
                state_d = S_BEAT;
              end
            end
            OP_PUSH: begin
              if (count_q < CntW'(DEPTH)) begin
                count_d = count_q + CntW'(1);
              end
            end
            OP_POP: begin
              if (count_q != '0) begin
                count_d = top;
                if (playing_q && cur_is_top) begin
                  state_d = S_POP;
                end
              end
            end
            OP_CLEAR: begin
              count_d = '0;
            end
            OP_START: begin
              if (!playing_q) begin
                offset_d  = start_offset_i;
                playing_d = 1'b1;
              end
            end
            OP_STOP: begin
              if (playing_q) begin
                playing_d = 1'b0;
                idx_vld_d = 1'b0;
                beats_d   = '0;
                state_d   = S_EMIT_ALL;
              end
            end
            default: ;
          endcase
        end
      end
      S_POP: begin
        beats_d   = '0;
        on_pend_d = 1'b0;
        if (!rd_q.rest) begin
          off_pend_d  = 1'b1;
          off_pitch_d = rd_sat;
          state_d     = S_EMIT_OFF;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_BEAT: begin
        off_pend_d  = cur_in_range && !rd_q.rest && (beats_q == BEATS_W'(1));
        off_pitch_d = rd_sat;
        on_pend_d   = 1'b0;
        if (beats_q > BEATS_W'(1)) begin
          beats_d = beats_q - BEATS_W'(1);
          state_d = S_IDLE;
        end else begin
          case (style_e'(style_q))
            STYLE_BACKWARD: begin
              dvd_d = idx_vld_q ? idx_ext + size_ext - LFSR_W'(1) : size_ext - LFSR_W'(1);
            end
            STYLE_RANDOM: begin
              dvd_d  = lfsr_adv;
              lfsr_d = lfsr_adv;
            end
            default: begin
              dvd_d = idx_vld_q ? idx_ext + LFSR_W'(1) : '0;
            end
          endcase
          rem_d     = '0;
          bit_cnt_d = '0;
          state_d   = S_DIV;
        end
      end
      S_DIV: begin
        rem_d     = rem_next[CntW-1:0];
        dvd_d     = {dvd_q[LFSR_W-2:0], 1'b0};
        bit_cnt_d = bit_cnt_q + BitW'(1);
        if (bit_cnt_q == BitW'(LFSR_W - 1)) begin
          idx_d     = rem_next[IdxW-1:0];
          idx_vld_d = 1'b1;
          state_d   = S_NRD;
        end
      end
      S_NRD: begin
        state_d = S_NEW;
      end
      S_NEW: begin
        beats_d    = rd_q.len;
        on_pend_d  = !rd_q.rest;
        on_pitch_d = rd_sat;
        if (off_pend_q) begin
          state_d = S_EMIT_OFF;
        end else if (!rd_q.rest) begin
          state_d = S_EMIT_ON;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_EMIT_OFF: begin
        if (slot_free) begin
          ld       = 1'b1;
          ld_kind  = EV_OFF;
          ld_pitch = off_pitch_q;
          ld_last  = !on_pend_q;
          state_d  = on_pend_q ? S_EMIT_ON : S_IDLE;
        end
      end
      S_EMIT_ON: begin
        if (slot_free) begin
          ld       = 1'b1;
          ld_kind  = EV_ON;
          ld_pitch = on_pitch_q;
          ld_last  = 1'b1;
          state_d  = S_IDLE;
        end
      end
      S_EMIT_ALL: begin
        if (slot_free) begin
          ld       = 1'b1;
          ld_kind  = EV_ALL_OFF;
          ld_pitch = '0;
          ld_last  = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (ld) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign event_kind_o = out_kind_q;
  assign note_pitch_o = out_pitch_q;
  assign last_o       = out_last_q;

endmodule
